// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL top level, gf2_10_inverse_unit.sv.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Checked on every rising edge, held off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Checked on every rising edge, including during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== rtl/gf2i_pkg.sv =====
// Package for the GF(2^10) inverse unit: field widths and field polynomial.
// No dependencies.
`timescale 1ns / 1ps

package gf2i_pkg;

    localparam int unsigned IN_W    = 16;             // input polynomial width
    localparam int unsigned FIELD_W = 10;             // field element width
    localparam int unsigned POLY_W  = FIELD_W + 1;    // width of m(x)
    localparam logic [POLY_W-1:0] FIELD_POLY = 11'h409;  // x^10 + x^3 + 1
    localparam int unsigned CNT_W   = $clog2(IN_W);

endpackage

// ===== rtl/gf2i_if.sv =====
// Valid/ready channel interfaces of the GF(2^10) inverse unit.
// Depends on gf2i_pkg for the payload widths.
`timescale 1ns / 1ps

interface gf2i_in_if;
    logic                         valid;
    logic                         ready;
    logic [gf2i_pkg::IN_W-1:0]    value_in;

    modport source (output valid, output value_in, input ready);
    modport sink   (input valid, input value_in, output ready);
endinterface

interface gf2i_out_if;
    logic                          valid;
    logic                          ready;
    logic [gf2i_pkg::FIELD_W-1:0]  reduced_value;
    logic [gf2i_pkg::FIELD_W-1:0]  inverse_value;
    logic                          has_inverse;

    modport source (output valid, output reduced_value, output inverse_value,
                    output has_inverse, input ready);
    modport sink   (input valid, input reduced_value, input inverse_value,
                    input has_inverse, output ready);
endinterface

// ===== rtl/gf2_10_inverse_unit.sv =====
// GF(2^10) inverse unit, top level: bit-serial reduction and binary inversion.
// Depends on gf2i_pkg, gf2i_if.sv and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
//
// Channel   Dir  Modport  Payload
// i_in      in   sink     value_in[15:0]
// o_out     out  source   reduced_value[9:0], inverse_value[9:0], has_inverse
//
// Sequence: a transaction is accepted in the idle state, then the reduction
// takes one input bit per cycle (Horner style, MSB first), then the inversion
// loop does one shift or one add per cycle, each add followed by a halving,
// and finally the output register is loaded. A zero remainder leaves the
// loop at once.
// Reset: synchronous, active low; clears the sequencer and output valid only.
// Stalls: the output register lets a new transaction be accepted while a
// result waits; a finished result holds in the loop until the slot is free.

module gf2_10_inverse_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    gf2i_in_if.sink      i_in,
    gf2i_out_if.source   o_out
);

    localparam int unsigned FW = gf2i_pkg::FIELD_W;
    localparam int unsigned PW = gf2i_pkg::POLY_W;
    localparam int unsigned IW = gf2i_pkg::IN_W;
    localparam int unsigned CW = gf2i_pkg::CNT_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RED  = 2'd1;
    localparam logic [1:0] ST_INV  = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;

    // Reduction datapath: input shifted out MSB first into a 10-bit remainder.
    logic [IW-1:0] r_sh, n_sh;
    logic [FW-1:0] r_acc, n_acc;
    logic [PW-1:0] red_step;

    // Inversion datapath: u/g1 and v/g2 pairs, with g*a == u or v (mod m).
    logic [PW-1:0] r_u, n_u;
    logic [PW-1:0] r_v, n_v;
    logic [FW-1:0] r_g1, n_g1;
    logic [FW-1:0] r_g2, n_g2;

    logic          r_out_valid, n_out_valid;
    logic [FW-1:0] r_out_red, n_out_red;
    logic [FW-1:0] r_out_inv, n_out_inv;
    logic          r_out_flag, n_out_flag;

    logic          in_fire;
    logic          out_free;
    logic          u_zero, u_one, v_one, fin;
    logic [FW-1:0] fin_inv;

    // Divide a cofactor by x modulo m(x): add m first when it is odd.
    function automatic logic [FW-1:0] half_mod(input logic [FW-1:0] g);
        logic [PW-1:0] t;
        t = {1'b0, g};
        if (g[0]) begin
            t = t ^ gf2i_pkg::FIELD_POLY;
        end
        return t[PW-1:1];
    endfunction

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;

    assign red_step = {r_acc, r_sh[IW-1]} ^ (r_acc[FW-1] ? gf2i_pkg::FIELD_POLY : '0);

    assign u_zero  = (r_u == '0);
    assign u_one   = (r_u == PW'(1));
    assign v_one   = (r_v == PW'(1));
    assign fin     = u_zero || u_one || v_one;
    assign fin_inv = u_one ? r_g1 : (v_one ? r_g2 : '0);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_sh        = r_sh;
        n_acc       = r_acc;
        n_u         = r_u;
        n_v         = r_v;
        n_g1        = r_g1;
        n_g2        = r_g2;
        n_out_valid = r_out_valid;
        n_out_red   = r_out_red;
        n_out_inv   = r_out_inv;
        n_out_flag  = r_out_flag;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_sh    = i_in.value_in;
                    n_acc   = '0;
                    n_cnt   = '0;
                    n_state = ST_RED;
                end
            end
            ST_RED: begin
                n_sh  = {r_sh[IW-2:0], 1'b0};
                n_acc = red_step[FW-1:0];
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(IW - 1)) begin
                    n_u     = {1'b0, red_step[FW-1:0]};
                    n_v     = gf2i_pkg::FIELD_POLY;
                    n_g1    = FW'(1);
                    n_g2    = '0;
                    n_state = ST_INV;
                end
            end
            ST_INV: begin
                if (fin) begin
                    // Result waits here until the output register frees up.
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out_red   = r_acc;
                        n_out_inv   = fin_inv;
                        n_out_flag  = !u_zero;
                        n_state     = ST_IDLE;
                    end
                end else if (!r_u[0]) begin
                    n_u  = r_u >> 1;
                    n_g1 = half_mod(r_g1);
                end else if (!r_v[0]) begin
                    n_v  = r_v >> 1;
                    n_g2 = half_mod(r_g2);
                end else if (r_u > r_v) begin
                    n_u  = r_u ^ r_v;
                    n_g1 = r_g1 ^ r_g2;
                end else begin
                    n_v  = r_v ^ r_u;
                    n_g2 = r_g2 ^ r_g1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sh       <= n_sh;
        r_acc      <= n_acc;
        r_u        <= n_u;
        r_v        <= n_v;
        r_g1       <= n_g1;
        r_g2       <= n_g2;
        r_out_red  <= n_out_red;
        r_out_inv  <= n_out_inv;
        r_out_flag <= n_out_flag;
    end

    assign i_in.ready          = (r_state == ST_IDLE);
    assign o_out.valid         = r_out_valid;
    assign o_out.reduced_value = r_out_red;
    assign o_out.inverse_value = r_out_inv;
    assign o_out.has_inverse   = r_out_flag;

    // A result without inverse comes only from a zero remainder.
    `ASSERT_CLK(a_noinv_zero, i_clk, i_rst_n, (r_out_valid && !r_out_flag) |-> (r_out_red == '0 && r_out_inv == '0), "no-inverse result with nonzero fields")
    // An invertible result always has a nonzero element and inverse.
    `ASSERT_CLK(a_inv_nonzero, i_clk, i_rst_n, (r_out_valid && r_out_flag) |-> (r_out_red != '0 && r_out_inv != '0), "inverse flagged for zero")
    // Accepted transaction starts the reduction from bit count zero.
    `ASSERT_CLK(a_start_red, i_clk, i_rst_n, in_fire |=> (r_state == ST_RED && r_cnt == '0), "reduction did not start")
    // Coprime pair never collapses to equal values inside the loop.
    `ASSERT_CLK(a_uv_distinct, i_clk, i_rst_n, (r_state == ST_INV && !u_zero) |-> (r_u != r_v), "u and v became equal")
    // u never grows past the field width.
    `ASSERT_CLK(a_u_width, i_clk, i_rst_n, (r_state == ST_INV) |-> !r_u[PW-1], "u exceeded field width")

endmodule

// ===== bench/gf2_10_inverse_unit_tb.sv =====
// Self-checking bench for gf2_10_inverse_unit: GF(2^10) reduction and inversion.
// Depends on gf2i_pkg, gf2i_if.sv and the RTL top level.
`timescale 1ns / 1ps

module gf2_10_inverse_unit_tb;

    localparam int unsigned IN_W    = gf2i_pkg::IN_W;
    localparam int unsigned FIELD_W = gf2i_pkg::FIELD_W;

    localparam int unsigned RANDOM_ITEMS = 600;
    localparam int unsigned PARK_CYCLES  = 400;  // long receiver hold-off
    localparam int unsigned DRAIN_CYCLES = 100;  // settle time after last result

    typedef struct packed {
        logic [FIELD_W-1:0] reduced;
        logic [FIELD_W-1:0] inverse;
        logic               invertible;
    } t_inverse_result;

    // Keeps the expected results in order and scores the observed ones.
    class inverse_scoreboard;
        t_inverse_result expected_results[$];
        int unsigned     failures = 0;

        static function int unsigned poly_len(bit [31:0] x);
            int unsigned n;
            n = 0;
            while (x != 0) begin
                n++;
                x >>= 1;
            end
            return n;
        endfunction

        // Carry-less long division.
        static function void poly_divide(input bit [31:0] num, input bit [31:0] den,
                                         output bit [31:0] quo, output bit [31:0] rem);
            int unsigned ld;
            int unsigned ln;
            int unsigned sh;
            quo = 0;
            ld  = poly_len(den);
            ln  = poly_len(num);
            while (ld > 0 && ln >= ld) begin
                sh   = ln - ld;
                quo ^= 32'd1 << sh;
                num ^= den << sh;
                ln   = poly_len(num);
            end
            rem = num;
        endfunction

        // Reduce mod m(x), then extended Euclid carrying only the cofactor of the operand.
        static function t_inverse_result predict_inverse(logic [IN_W-1:0] operand);
            bit [31:0]       quo;
            bit [31:0]       rem;
            bit [31:0]       r_prev;
            bit [31:0]       r_cur;
            bit [31:0]       s_prev;
            bit [31:0]       s_cur;
            bit [31:0]       prod;
            int              steps;
            t_inverse_result res;
            poly_divide({16'd0, operand}, 32'(gf2i_pkg::FIELD_POLY), quo, rem);
            res.reduced = rem[FIELD_W-1:0];
            r_prev = 32'(gf2i_pkg::FIELD_POLY);
            r_cur  = {22'd0, rem[FIELD_W-1:0]};
            s_prev = 0;
            s_cur  = 1;
            steps  = 0;
            while (steps < 16 && r_cur != 0) begin
                poly_divide(r_prev, r_cur, quo, rem);
                prod = 0;
                for (int i = 0; i < 11; i++) begin
                    if (quo[i]) begin
                        prod ^= {21'd0, s_cur[10:0]} << i;
                    end
                end
                r_prev = r_cur;
                r_cur  = rem;
                prod   = s_prev ^ prod;
                s_prev = s_cur;
                s_cur  = prod;
                steps++;
            end
            res.invertible = (r_prev == 1);
            res.inverse    = res.invertible ? s_prev[FIELD_W-1:0] : '0;
            return res;
        endfunction

        function void note_operand(logic [IN_W-1:0] operand);
            expected_results.push_back(predict_inverse(operand));
        endfunction

        function void check_result(t_inverse_result got);
            t_inverse_result want;
            if (expected_results.size() == 0) begin
                failures++;
                if (failures <= 10) begin
                    $display("ERROR: result with nothing expected: red=%h inv=%h ok=%b",
                             got.reduced, got.inverse, got.invertible);
                end
                return;
            end
            want = expected_results.pop_front();
            if (got.reduced !== want.reduced || got.inverse !== want.inverse ||
                got.invertible !== want.invertible) begin
                failures++;
                if (failures <= 10) begin
                    $display("ERROR: mismatch red exp %h got %h, inv exp %h got %h, ok exp %b got %b",
                             want.reduced, got.reduced, want.inverse, got.inverse,
                             want.invertible, got.invertible);
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    gf2i_in_if  in_ch();
    gf2i_out_if out_ch();

    gf2_10_inverse_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    inverse_scoreboard sb = new();

    int unsigned burst_left   = 0;
    bit          sender_low   = 1'b1;  // valid already scheduled low
    bit          park_request = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Monitor: both channels sampled at the edge, inputs noted before results checked.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                sb.note_operand(in_ch.value_in);
            end
            if (out_ch.valid && out_ch.ready) begin
                sb.check_result({out_ch.reduced_value, out_ch.inverse_value,
                                 out_ch.has_inverse});
            end
        end
    end

    // Receiver: phases of steady, random and sparse ready, plus one long hold-off.
    initial begin
        int unsigned hold_left;
        int unsigned phase_left;
        int unsigned mode;
        int unsigned tick;
        hold_left  = 0;
        phase_left = 0;
        mode       = 0;
        tick       = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (park_request) begin
                park_request = 1'b0;
                hold_left    = PARK_CYCLES;
            end
            if (!i_rst_n) begin
                out_ch.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                if (phase_left == 0) begin
                    mode       = $urandom_range(0, 3);
                    phase_left = $urandom_range(10, 80);
                end
                phase_left--;
                case (mode)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= 1'($urandom_range(0, 1));
                    2: out_ch.ready <= (tick % 4 == 0);
                    default: out_ch.ready <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    // Offer one operand and wait for its transaction; bursts end in a random gap.
    task automatic offer_operand(input logic [IN_W-1:0] operand);
        in_ch.valid    <= 1'b1;
        in_ch.value_in <= operand;
        sender_low      = 1'b0;
        do @(posedge i_clk); while (!in_ch.ready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            in_ch.valid <= 1'b0;
            sender_low   = 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(0, 30);
        end
    endtask

    // Stop offering and wait until every expected result has come back.
    task automatic wait_results_drained();
        if (!sender_low) begin
            in_ch.valid <= 1'b0;
            sender_low   = 1'b1;
        end
        @(posedge i_clk);
        while (sb.expected_results.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        logic [IN_W-1:0] directed[] = '{
            16'h0000, 16'h0001, 16'h0002, 16'hFFFF, 16'h0409, 16'h0812, 16'h8120,
            16'h0400, 16'h03FF, 16'h0200, 16'h8000, 16'h0408, 16'h0401, 16'h7FFF,
            16'hAAAA, 16'h5555, 16'h0003, 16'h0008, 16'h0100, 16'h1000, 16'h0409 ^ 16'h8120
        };
        logic [IN_W-1:0] operand;
        logic [5:0]      factor;

        i_rst_n        <= 1'b0;
        in_ch.valid    <= 1'b0;
        in_ch.value_in <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Extremes, multiples of m(x) and degree-ten operands.
        foreach (directed[i]) offer_operand(directed[i]);
        wait_results_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 200) park_request = 1'b1;  // sender keeps going through the hold
            if (n == 400) wait_results_drained();
            case ($urandom_range(0, 9)) inside
                [0:3]:      operand = IN_W'($urandom_range(0, 16'hFFFF));
                [4:5]:      operand = IN_W'($urandom_range(0, 10'h3FF));
                6: begin
                    // multiple of m(x), reduces to zero
                    factor  = 6'($urandom_range(0, 63));
                    operand = '0;
                    for (int b = 0; b < 6; b++) begin
                        if (factor[b]) operand ^= IN_W'(gf2i_pkg::FIELD_POLY) << b;
                    end
                end
                7:          operand = 16'h0400 | IN_W'($urandom_range(0, 10'h3FF));
                8:          operand = 16'd1 << $urandom_range(0, 15);
                default:    operand = {6'($urandom_range(1, 6'h3F)), 10'($urandom)};
            endcase
            offer_operand(operand);
        end

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.failures == 0 && sb.expected_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== gf2_10_inverse_unit.f =====
+incdir+rtl
rtl/gf2i_pkg.sv
rtl/gf2i_if.sv
rtl/gf2_10_inverse_unit.sv
bench/gf2_10_inverse_unit_tb.sv
